// ----- sv/zwf_pkg.sv -----
// ============================================================================
// Zambretti forecaster package
// Shared widths, codes, lookup tables and the result record.
// ============================================================================
package zwf_pkg;

    localparam int HISTORY_DEPTH_DEF = 10;
    localparam int P_W               = 11;
    localparam int SUM_W             = 13;
    localparam int CLASS_W           = 3;
    localparam int Z_W               = 5;
    localparam int TREND_W           = 2;
    localparam int MONTH_W           = 4;
    localparam int INTERVAL_W        = 8;
    localparam int CFG_DATA_W        = 8;
    localparam int S_TDATA_W         = 16;
    localparam int M_TDATA_W         = 16;
    localparam int RESULT_W          = CLASS_W + Z_W + TREND_W + 1;

    localparam logic [MONTH_W-1:0]    MONTH_RESET    = 4'd12;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd10;

    localparam logic REG_MONTH    = 1'b0;
    localparam logic REG_INTERVAL = 1'b1;

    localparam logic [TREND_W-1:0] TREND_STEADY  = 2'd0;
    localparam logic [TREND_W-1:0] TREND_RISING  = 2'd1;
    localparam logic [TREND_W-1:0] TREND_FALLING = 2'd2;

    localparam logic [CLASS_W-1:0] CLASS_SUNNY     = 3'd0;
    localparam logic [CLASS_W-1:0] CLASS_SUNNY_CLD = 3'd1;
    localparam logic [CLASS_W-1:0] CLASS_CLOUDY    = 3'd2;
    localparam logic [CLASS_W-1:0] CLASS_WORSENING = 3'd3;
    localparam logic [CLASS_W-1:0] CLASS_RAINY     = 3'd4;

    typedef struct packed {
        logic                full;
        logic [TREND_W-1:0]  trend;
        logic [Z_W-1:0]      znum;
        logic [CLASS_W-1:0]  wclass;
    } zwf_result_t;

    function automatic logic [2:0] band_of(input logic [P_W-1:0] p);
        logic [2:0] b;
        b = 3'd0;
        if (p < 11'd1030) b = 3'd1;
        if (p < 11'd1020) b = 3'd2;
        if (p < 11'd1010) b = 3'd3;
        if (p < 11'd1000) b = 3'd4;
        if (p < 11'd990)  b = 3'd5;
        if (p < 11'd980)  b = 3'd6;
        if (p < 11'd970)  b = 3'd7;
        return b;
    endfunction

    function automatic logic [Z_W-1:0] z_fall(input logic summer, input logic [2:0] b);
        logic [Z_W-1:0] z;
        case (b)
            3'd0:    z = 5'd2;
            3'd1:    z = 5'd8;
            3'd2:    z = summer ? 5'd18 : 5'd15;
            3'd3:    z = 5'd21;
            3'd4:    z = summer ? 5'd24 : 5'd22;
            3'd5:    z = 5'd24;
            default: z = 5'd26;
        endcase
        return z;
    endfunction

    function automatic logic [Z_W-1:0] z_rise(input logic summer, input logic [2:0] b);
        logic [Z_W-1:0] z;
        case (b)
            3'd0:    z = 5'd1;
            3'd1:    z = 5'd2;
            3'd2:    z = summer ? 5'd3 : 5'd6;
            3'd3:    z = 5'd7;
            3'd4:    z = summer ? 5'd9 : 5'd10;
            3'd5:    z = summer ? 5'd12 : 5'd13;
            default: z = 5'd17;
        endcase
        return z;
    endfunction

    function automatic logic [Z_W-1:0] z_steady(input logic [2:0] b);
        logic [Z_W-1:0] z;
        case (b)
            3'd0:    z = 5'd1;
            3'd1:    z = 5'd2;
            3'd2:    z = 5'd11;
            3'd3:    z = 5'd14;
            3'd4:    z = 5'd19;
            3'd5:    z = 5'd23;
            3'd6:    z = 5'd24;
            default: z = 5'd26;
        endcase
        return z;
    endfunction

    // Exact for every sum below 8192: floor(s * 2731 / 8192) == s / 3.
    function automatic logic [P_W-1:0] div3(input logic [SUM_W-1:0] s);
        logic [SUM_W+11:0] prod;
        prod = s * 12'd2731;
        return prod[SUM_W+10:SUM_W];
    endfunction

endpackage

// ----- sv/zwf_cell.sv -----
// ============================================================================
// History cell
// Holds one pressure sample; loads a new sample or takes its neighbor's.
// ============================================================================
module zwf_cell
    import zwf_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           shift_en,
    input  logic           load_en,
    input  logic [P_W-1:0] shift_in,
    input  logic [P_W-1:0] sample,
    output logic [P_W-1:0] q
);

    logic [P_W-1:0] q_reg;
    logic [P_W-1:0] q_next;

    always_comb begin
        q_next = q_reg;
        if (shift_en) begin
            q_next = shift_in;
        end else if (load_en) begin
            q_next = sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_reg <= '0;
        end else begin
            q_reg <= q_next;
        end
    end

    assign q = q_reg;

endmodule

// ----- sv/zwf_classify.sv -----
// ============================================================================
// Forecast classifier
// Averages, Zambretti number, trend and weather class from the history ends.
// ============================================================================
module zwf_classify
    import zwf_pkg::*;
(
    input  logic [P_W-1:0]     old0,
    input  logic [P_W-1:0]     old1,
    input  logic [P_W-1:0]     old2,
    input  logic [P_W-1:0]     new0,
    input  logic [P_W-1:0]     new1,
    input  logic [P_W-1:0]     new2,
    input  logic [P_W-1:0]     pressure,
    input  logic [MONTH_W-1:0] month,
    output zwf_result_t        result
);

    logic [SUM_W-1:0] new_sum;
    logic [SUM_W-1:0] old_sum;
    logic [P_W-1:0]   cur;
    logic [P_W-1:0]   prev;
    logic [2:0]       band;
    logic             summer;
    logic [Z_W-1:0]   z;
    logic [TREND_W-1:0] trend;
    logic             full;
    logic [CLASS_W-1:0] wclass;

    always_comb begin
        new_sum = SUM_W'(new0) + SUM_W'(new1) + SUM_W'(new2);
        old_sum = SUM_W'(old0) + SUM_W'(old1) + SUM_W'(old2);
        cur     = div3(new_sum);
        prev    = div3(old_sum);
        band    = band_of(cur);
        summer  = (month >= 4'd4) && (month <= 4'd9);

        if (cur < prev) begin
            z = z_fall(summer, band);
        end else if (cur > prev) begin
            z = z_rise(summer, band);
        end else begin
            z = z_steady(band);
        end

        if ({1'b0, new_sum} >= {1'b0, old_sum} + 14'd3) begin
            trend = TREND_RISING;
        end else if ({1'b0, old_sum} >= {1'b0, new_sum} + 14'd3) begin
            trend = TREND_FALLING;
        end else begin
            trend = TREND_STEADY;
        end

        full = (new0 != '0) && (old0 != '0);

        if (full) begin
            case (trend)
                TREND_RISING: begin
                    if (z < 5'd3)       wclass = CLASS_SUNNY;
                    else if (z <= 5'd9)  wclass = CLASS_SUNNY_CLD;
                    else if (z <= 5'd17) wclass = CLASS_CLOUDY;
                    else                 wclass = CLASS_RAINY;
                end
                TREND_FALLING: begin
                    if (z < 5'd4)       wclass = CLASS_SUNNY;
                    else if (z < 5'd14) wclass = CLASS_SUNNY_CLD;
                    else if (z < 5'd19) wclass = CLASS_WORSENING;
                    else if (z < 5'd21) wclass = CLASS_CLOUDY;
                    else                wclass = CLASS_RAINY;
                end
                default: begin
                    if (z < 5'd5)        wclass = CLASS_SUNNY;
                    else if (z <= 5'd11) wclass = CLASS_SUNNY_CLD;
                    else if (z < 5'd14)  wclass = CLASS_CLOUDY;
                    else if (z < 5'd19)  wclass = CLASS_WORSENING;
                    else                 wclass = CLASS_RAINY;
                end
            endcase
        end else begin
            if (pressure < 11'd1005)       wclass = CLASS_RAINY;
            else if (pressure <= 11'd1015) wclass = CLASS_CLOUDY;
            else if (pressure < 11'd1025)  wclass = CLASS_SUNNY_CLD;
            else                           wclass = CLASS_RAINY;
        end

        result.full   = full;
        result.trend  = trend;
        result.znum   = z;
        result.wclass = wclass;
    end

endmodule

// ----- sv/zambretti_weather_forecaster.sv -----
// ============================================================================
// Zambretti weather forecaster
// Samples pressure ticks into a row of history cells and classes the weather.
//
//   channel  direction  tdata fields (lowest bit first)
//   s_       in         sea_pressure[10:0]
//   m_       out        weather_class[2:0], zambretti_number[7:3],
//                       trend[9:8], history_full[10]
//   cfg_     in         index 0 month, index 1 sample_interval
//
// One transaction is accepted per cycle while s_tready is high.
// The history cells update at the accepting edge of a sampled transaction; the classifier reads them
// in the following cycle and its result is held in the output register.
// Reset clears the history, counters and both pipeline stages at once.
// A stalled output holds the middle stage, which in turn holds s_tready low.
// ============================================================================
module zambretti_weather_forecaster
    import zwf_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // sea_pressure
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // weather_class, zambretti_number, trend, history_full
    input  logic                  cfg_wr_en,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int FC_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int IDX_W = $clog2(HISTORY_DEPTH);

    logic [MONTH_W-1:0]    month_reg;
    logic [INTERVAL_W-1:0] interval_reg;
    logic [INTERVAL_W-1:0] tick_reg;
    logic [INTERVAL_W-1:0] tick_next;
    logic [FC_W-1:0]       fill_reg;
    logic [FC_W-1:0]       fill_next;
    logic                  v1_reg;
    logic [P_W-1:0]        p_reg;
    logic                  m_valid_reg;
    zwf_result_t           res_reg;

    logic [P_W-1:0]        pressure;
    logic [INTERVAL_W:0]   tick_inc;
    logic                  accept;
    logic                  adv_out;
    logic                  sample;
    logic                  hist_full;
    logic [P_W-1:0]        hist [HISTORY_DEPTH];
    zwf_result_t           result;

    assign pressure  = s_tdata[P_W-1:0];
    assign adv_out   = !m_valid_reg || m_tready;
    assign s_tready  = !v1_reg || adv_out;
    assign accept    = s_tvalid && s_tready;
    assign tick_inc  = {1'b0, tick_reg} + 9'd1;
    assign sample    = accept && (tick_inc > {1'b0, interval_reg});
    assign hist_full = (fill_reg == FC_W'(HISTORY_DEPTH));

    always_comb begin
        tick_next = tick_reg;
        fill_next = fill_reg;
        if (accept) begin
            tick_next = sample ? '0 : tick_inc[INTERVAL_W-1:0];
        end
        if (sample && !hist_full) begin
            fill_next = fill_reg + FC_W'(1);
        end
    end

    genvar i;
    generate
        for (i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
            logic [P_W-1:0] shift_src;
            if (i == HISTORY_DEPTH - 1) begin : g_last
                assign shift_src = pressure;
            end else begin : g_mid
                assign shift_src = hist[i+1];
            end
            zwf_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (sample && hist_full),
                .load_en  (sample && !hist_full && (fill_reg[IDX_W-1:0] == IDX_W'(i))),
                .shift_in (shift_src),
                .sample   (pressure),
                .q        (hist[i])
            );
        end
    endgenerate

    zwf_classify u_classify (
        .old0     (hist[0]),
        .old1     (hist[1]),
        .old2     (hist[2]),
        .new0     (hist[HISTORY_DEPTH-1]),
        .new1     (hist[HISTORY_DEPTH-2]),
        .new2     (hist[HISTORY_DEPTH-3]),
        .pressure (p_reg),
        .month    (month_reg),
        .result   (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            month_reg    <= MONTH_RESET;
            interval_reg <= INTERVAL_RESET;
            tick_reg     <= '0;
            fill_reg     <= '0;
            v1_reg       <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MONTH:    month_reg    <= cfg_wdata[MONTH_W-1:0];
                    REG_INTERVAL: interval_reg <= cfg_wdata[INTERVAL_W-1:0];
                    default:      month_reg    <= month_reg;
                endcase
            end
            tick_reg    <= tick_next;
            fill_reg    <= fill_next;
            v1_reg      <= accept || (v1_reg && !adv_out);
            if (adv_out) begin
                m_valid_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p_reg <= pressure;
        end
        if (adv_out && v1_reg) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), res_reg};

endmodule

// ----- sv/zwf_checker.sv -----
// ============================================================================
// Forecaster port checker
// Watches the result channel for legal field codes, stable stalls and no valid right after reset.
// ============================================================================
module zwf_checker
    import zwf_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("Result transaction changed while stalled.");

    a_reset_idle: assert property (@(posedge aclk)
        aresetn && $past(!aresetn) |-> !m_tvalid)
        else $error("Result valid right after reset.");

    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] <= CLASS_RAINY) && (m_tdata[9:8] != 2'd3))
        else $error("Weather class or trend code out of range.");

    a_znum_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:3] >= 5'd1) && (m_tdata[7:3] <= 5'd26))
        else $error("Zambretti number out of range.");

endmodule

bind zambretti_weather_forecaster zwf_checker u_zwf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
